FILE: rtl/metadata_frame_classifier_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the metadata frame classifier
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef METADATA_FRAME_CLASSIFIER_MACROS_SVH
`define METADATA_FRAME_CLASSIFIER_MACROS_SVH

// Same-cycle implication
`define MFC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mfc assertion failed");

// Next-cycle implication
`define MFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mfc assertion failed");

`endif

FILE: rtl/mfc_pkg.sv
// ----------------------------------------------------------------------------
// mfc_pkg
// Types and constants shared by the metadata frame classifier modules.
// ----------------------------------------------------------------------------
package mfc_pkg;

  // Configuration port
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  typedef enum logic {
    RegTargetAddress = 1'b0,
    RegTargetPort    = 1'b1
  } reg_idx_e;

  localparam logic [31:0] TargetAddressReset = 32'hA9FE_A9FE;
  localparam logic [15:0] TargetPortReset    = 16'd80;

  // Frame decoding
  localparam logic [15:0] KindArp    = 16'h0806;
  localparam logic [15:0] KindIpv4   = 16'h0800;
  localparam logic [5:0]  OffsetMax  = 6'd63;
  localparam logic [5:0]  ArpLastOff = 6'd41;   // 42-byte minimum ARP frame
  localparam logic [5:0]  TcpLastOff = 6'd53;   // 54-byte minimum TCP frame
  localparam logic [8:0]  QueueCount = 9'd256;

  typedef struct packed {
    logic [31:0] target_address;
    logic [15:0] intercept_port;
  } cfg_t;

  typedef struct packed {
    logic       verdict;
    logic [7:0] socket_queue;
  } result_t;

endpackage

FILE: rtl/metadata_frame_classifier.sv
// ----------------------------------------------------------------------------
// metadata_frame_classifier
// Classifies Ethernet frames byte by byte and queues one redirect/pass
// verdict per frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  frame     in         push / full             frame_byte_i, end_of_frame_i,
//                                               queue_number_i
//  result    out        empty / pop             verdict_o, socket_queue_o
//  config    in         psel/penable/pwrite     paddr, pwdata, prdata
//
//  One byte is taken every cycle while full is low; the parser state updates on each byte.
//  A frame's verdict is queued with its final byte, behind any unread verdicts.
//  full rises only when ResultDepth verdicts wait unread; the parser then
//  stalls until pop frees an entry.
//  Reset is asynchronous; afterwards the block takes bytes at once.
// ----------------------------------------------------------------------------
module metadata_frame_classifier #(
  parameter int unsigned ResultDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // frame bytes
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    frame_byte_i,
  input  logic                          end_of_frame_i,
  input  logic [7:0]                    queue_number_i,
  // verdicts
  output logic                          empty,
  input  logic                          pop,
  output logic                          verdict_o,
  output logic [7:0]                    socket_queue_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfc_pkg::AddrWidth-1:0] paddr,
  input  logic [mfc_pkg::DataWidth-1:0] pwdata,
  output logic [mfc_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);

  mfc_pkg::cfg_t    cfg;
  mfc_pkg::result_t res_in, res_out;
  logic             res_push;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  mfc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mfc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .accept_i       (in_acc),
    .frame_byte_i   (frame_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .queue_number_i (queue_number_i),
    .res_valid_o    (res_push),
    .res_o          (res_in)
  );

  mfc_fifo #(
    .Depth (ResultDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (out_acc),
    .data_o  (res_out),
    .full_o  (full),
    .empty_o (empty)
  );

  assign verdict_o      = res_out.verdict;
  assign socket_queue_o = res_out.socket_queue;

endmodule

FILE: rtl/mfc_cfg.sv
// ----------------------------------------------------------------------------
// mfc_cfg
// APB-style register file holding the intercept address and port.
// ----------------------------------------------------------------------------
module mfc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mfc_pkg::AddrWidth-1:0]    paddr,
  input  logic [mfc_pkg::DataWidth-1:0]    pwdata,
  output logic [mfc_pkg::DataWidth-1:0]    prdata,
  output logic                             pready,
  output mfc_pkg::cfg_t                    cfg_o
);

  logic [31:0]       addr_q, addr_d;
  logic [15:0]       port_q, port_d;
  logic              wr_en;
  mfc_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = mfc_pkg::reg_idx_e'(paddr[mfc_pkg::AddrWidth-1]);

  // Decode the write request
  always_comb begin
    addr_d = addr_q;
    port_d = port_q;
    if (wr_en) begin
      unique case (reg_idx)
        mfc_pkg::RegTargetAddress: addr_d = pwdata;
        mfc_pkg::RegTargetPort:    port_d = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= mfc_pkg::TargetAddressReset;
      port_q <= mfc_pkg::TargetPortReset;
    end else begin
      addr_q <= addr_d;
      port_q <= port_d;
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      mfc_pkg::RegTargetAddress: prdata = addr_q;
      mfc_pkg::RegTargetPort:    prdata = {16'd0, port_q};
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o.target_address = addr_q;
  assign cfg_o.intercept_port = port_q;

endmodule

FILE: rtl/mfc_front.sv
// ----------------------------------------------------------------------------
// mfc_front
// Byte parser: tracks the offset, checks ARP and IPv4/TCP fields, and issues
// one verdict on the final byte of each frame.
// ----------------------------------------------------------------------------
`include "metadata_frame_classifier_macros.svh"

module mfc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mfc_pkg::cfg_t    cfg_i,
  input  logic             accept_i,
  input  logic [7:0]       frame_byte_i,
  input  logic             end_of_frame_i,
  input  logic [7:0]       queue_number_i,
  output logic             res_valid_o,
  output mfc_pkg::result_t res_o
);

  logic [5:0]  off_q, off_d;
  logic [15:0] kind_q, kind_d, kind_n;
  logic        arp_q, arp_d, arp_n;
  logic        tcp_q, tcp_d, tcp_n;
  logic [7:0]  lq_q, lq_d, lq_n;
  logic        arp_chk, tcp_chk;
  logic [7:0]  arp_want, tcp_want;
  logic        redirect;

  // ARP field checks by offset
  always_comb begin
    arp_chk  = 1'b1;
    arp_want = 8'h00;
    unique case (off_q)
      6'd14:   arp_want = 8'h00;   // hardware type
      6'd15:   arp_want = 8'h01;
      6'd16:   arp_want = 8'h08;   // protocol type
      6'd17:   arp_want = 8'h00;
      6'd18:   arp_want = 8'd6;    // hardware length
      6'd19:   arp_want = 8'd4;    // protocol length
      6'd20:   arp_want = 8'h00;   // opcode: request
      6'd21:   arp_want = 8'h01;
      6'd38:   arp_want = cfg_i.target_address[31:24];  // target IP
      6'd39:   arp_want = cfg_i.target_address[23:16];
      6'd40:   arp_want = cfg_i.target_address[15:8];
      6'd41:   arp_want = cfg_i.target_address[7:0];
      default: arp_chk  = 1'b0;
    endcase
  end

  // IPv4/TCP field checks by offset
  always_comb begin
    tcp_chk  = 1'b1;
    tcp_want = 8'h00;
    unique case (off_q)
      6'd23:   tcp_want = 8'd6;    // IP protocol: TCP
      6'd30:   tcp_want = cfg_i.target_address[31:24];  // destination IP
      6'd31:   tcp_want = cfg_i.target_address[23:16];
      6'd32:   tcp_want = cfg_i.target_address[15:8];
      6'd33:   tcp_want = cfg_i.target_address[7:0];
      6'd36:   tcp_want = cfg_i.intercept_port[15:8];   // destination port
      6'd37:   tcp_want = cfg_i.intercept_port[7:0];
      default: tcp_chk  = 1'b0;
    endcase
  end

  // Fold the current byte into the frame state
  always_comb begin
    kind_n = kind_q;
    lq_n   = lq_q;
    if (off_q == 6'd0) begin
      lq_n = queue_number_i;
    end
    if (off_q == 6'd12) begin
      kind_n[15:8] = frame_byte_i;
    end else if (off_q == 6'd13) begin
      kind_n[7:0] = frame_byte_i;
    end
    arp_n = arp_q && !(arp_chk && (frame_byte_i != arp_want));
    tcp_n = tcp_q && !(tcp_chk && (frame_byte_i != tcp_want));
  end

  // Verdict for a frame ending on this byte
  always_comb begin
    redirect = ((kind_n == mfc_pkg::KindArp) && (off_q >= mfc_pkg::ArpLastOff) && arp_n) ||
               ((kind_n == mfc_pkg::KindIpv4) && (off_q >= mfc_pkg::TcpLastOff) && tcp_n);
    if ({1'b0, lq_n} >= mfc_pkg::QueueCount) begin
      redirect = 1'b0;
    end
  end

  assign res_valid_o        = accept_i && end_of_frame_i;
  assign res_o.verdict      = redirect;
  assign res_o.socket_queue = redirect ? lq_n : 8'd0;

  // Advance, or clear after the final byte
  always_comb begin
    off_d  = off_q;
    kind_d = kind_q;
    arp_d  = arp_q;
    tcp_d  = tcp_q;
    lq_d   = lq_q;
    if (accept_i) begin
      if (end_of_frame_i) begin
        off_d  = '0;
        kind_d = '0;
        arp_d  = 1'b1;
        tcp_d  = 1'b1;
        lq_d   = '0;
      end else begin
        off_d  = (off_q < mfc_pkg::OffsetMax) ? off_q + 6'd1 : off_q;
        kind_d = kind_n;
        arp_d  = arp_n;
        tcp_d  = tcp_n;
        lq_d   = lq_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      kind_q <= '0;
      arp_q  <= 1'b1;
      tcp_q  <= 1'b1;
      lq_q   <= '0;
    end else begin
      off_q  <= off_d;
      kind_q <= kind_d;
      arp_q  <= arp_d;
      tcp_q  <= tcp_d;
      lq_q   <= lq_d;
    end
  end

  `MFC_ASSERT_NEXT(a_clear_after_last, accept_i && end_of_frame_i,
                   (off_q == 6'd0) && arp_q && tcp_q && (kind_q == 16'd0))
  `MFC_ASSERT_NEXT(a_offset_saturates,
                   accept_i && !end_of_frame_i && (off_q == mfc_pkg::OffsetMax),
                   off_q == mfc_pkg::OffsetMax)

endmodule

FILE: rtl/mfc_fifo.sv
// ----------------------------------------------------------------------------
// mfc_fifo
// Short result queue between the parser and the result port.
// ----------------------------------------------------------------------------
`include "metadata_frame_classifier_macros.svh"

module mfc_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mfc_pkg::result_t data_i,
  input  logic             pop_i,
  output mfc_pkg::result_t data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mfc_pkg::result_t    mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold the entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `MFC_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CntW'(Depth))
  `MFC_ASSERT_NEXT(a_push_grows, push_i && !pop_i,
                   count_q == $past(count_q) + CntW'(1))

endmodule
